// File: design/sensor_window_midpoint_align_unit_assert.svh
// Assertion macros for the sensor window midpoint align unit.
`ifndef SENSOR_WINDOW_MIDPOINT_ALIGN_UNIT_ASSERT_SVH
`define SENSOR_WINDOW_MIDPOINT_ALIGN_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SWMA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SWMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/swma_pkg.sv
// Shared types and constants for the sensor window midpoint align unit.
package swma_pkg;

    localparam int WINDOW_LEN_DEF = 10;
    localparam int POS_BITS_DEF   = 16;

    localparam int SAMPLE_W   = 10;
    localparam int PHASE_W    = 3;
    localparam int THRESH_W   = 10;
    localparam int REV_W      = 15;
    localparam int LAG_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [THRESH_W-1:0] LOW_THRESHOLD_RST  = THRESH_W'(275);
    localparam logic [THRESH_W-1:0] HIGH_THRESHOLD_RST = THRESH_W'(400);
    localparam logic [REV_W-1:0]    REV_STEPS_RST      = REV_W'(2048);
    localparam logic [LAG_W-1:0]    LAG_STEPS_RST      = LAG_W'(10);

    typedef enum logic [PHASE_W-1:0] {
        PH_SEEK_LOW  = 3'd0,
        PH_SEEK_RISE = 3'd1,
        PH_SEEK_FALL = 3'd2,
        PH_DONE      = 3'd3,
        PH_ABORTED   = 3'd4
    } phase_t;

    typedef enum logic {
        CMD_RESTART = 1'b0,
        CMD_SAMPLE  = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_THRESHOLD  = 2'd0,
        REG_HIGH_THRESHOLD = 2'd1,
        REG_REV_STEPS      = 2'd2,
        REG_LAG_STEPS      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [THRESH_W-1:0] low_threshold;
        logic [THRESH_W-1:0] high_threshold;
        logic [REV_W-1:0]    revolution_steps;
        logic [LAG_W-1:0]    lag_steps;
    } cfg_t;

endpackage

// File: design/swma_if.sv
// Valid/ready channel interfaces for sensor items and alignment results.
interface swma_in_if
    import swma_pkg::*;
#(
    parameter int POSITION_BITS = POS_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic                            op;
    logic [SAMPLE_W-1:0]             sample;
    logic signed [POSITION_BITS-1:0] position;

    modport source (output valid, output op, output sample, output position, input ready);
    modport sink   (input valid, input op, input sample, input position, output ready);
endinterface

interface swma_out_if
    import swma_pkg::*;
#(
    parameter int POSITION_BITS = POS_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic [PHASE_W-1:0]              phase;
    logic [SAMPLE_W-1:0]             average;
    logic                            found;
    logic signed [POSITION_BITS-1:0] midpoint;

    modport source (output valid, output phase, output average, output found,
                    output midpoint, input ready);
    modport sink   (input valid, input phase, input average, input found,
                    input midpoint, output ready);
endinterface

// File: design/swma_front.sv
// Front end: accepts sensor items, classifies them and queues them for the back end.
module swma_front
    import swma_pkg::*;
#(
    parameter int POSITION_BITS = POS_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    swma_in_if.sink                         in_ch,
    output logic                            q_valid,
    input  logic                            q_ready,
    output cmd_t                            q_kind,
    output logic [SAMPLE_W-1:0]             q_sample,
    output logic signed [POSITION_BITS-1:0] q_position
);

    localparam int QDEPTH = 2;

    cmd_t                            kind_mem [QDEPTH];
    logic [SAMPLE_W-1:0]             smp_mem  [QDEPTH];
    logic signed [POSITION_BITS-1:0] pos_mem  [QDEPTH];

    logic [1:0] cnt_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       push;
    logic       pop;

    assign in_ch.ready = (cnt_reg != 2'(QDEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign pop         = q_valid && q_ready;

    assign q_valid    = (cnt_reg != 2'd0);
    assign q_kind     = kind_mem[rd_ptr_reg];
    assign q_sample   = smp_mem[rd_ptr_reg];
    assign q_position = pos_mem[rd_ptr_reg];

    // Op zero restarts the search; everything else is a sample.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_mem[wr_ptr_reg] <= in_ch.op ? CMD_SAMPLE : CMD_RESTART;
            smp_mem[wr_ptr_reg]  <= in_ch.sample;
            pos_mem[wr_ptr_reg]  <= in_ch.position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// File: design/swma_div.sv
// Restoring divider: one quotient bit per cycle, gives the remainder.
module swma_div
    import swma_pkg::*;
#(
    parameter int DIV_W = 18,
    parameter int DVS_W = REV_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_diff;
    logic             ge;
    logic [DVS_W-1:0] rem_next;

    assign rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign ge       = (rem_sh >= {1'b0, dvs_reg});
    assign rem_next = ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= CNT_W'(DIV_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                quo_reg <= {quo_reg[DIV_W-2:0], ge};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: design/swma_back.sv
// Back end: search phases, moving-average window, edge capture and midpoint math.
module swma_back
    import swma_pkg::*;
#(
    parameter int WINDOW_LEN    = WINDOW_LEN_DEF,
    parameter int POSITION_BITS = POS_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cfg_t                            cfg,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  cmd_t                            q_kind,
    input  logic [SAMPLE_W-1:0]             q_sample,
    input  logic signed [POSITION_BITS-1:0] q_position,
    swma_out_if.source                      out_ch
);

    localparam int WIN_AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W  = $clog2(WINDOW_LEN * ((1 << SAMPLE_W) - 1) + 1);
    localparam int EDGE_W = POSITION_BITS + 1;
    localparam int CS_W   = ((EDGE_W > REV_W + 1) ? EDGE_W : REV_W + 1) + 2;
    localparam int MAG_W  = CS_W - 1;
    localparam int DIV_W  = MAG_W;
    localparam int DVS_W  = REV_W;
    localparam int AVG_SH = SUM_W + $clog2(WINDOW_LEN);
    localparam int RCP_W  = AVG_SH + 1;
    localparam int PROD_W = SUM_W + RCP_W;

    // Rounded-up reciprocal of the window length; exact for every reachable sum.
    localparam logic [RCP_W-1:0] AVG_RCP =
        RCP_W'(((64'd1 << AVG_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    localparam logic signed [CS_W-1:0] SAT_HI =
        CS_W'((64'sd1 <<< (POSITION_BITS - 1)) - 64'sd1);
    localparam logic signed [CS_W-1:0] SAT_LO = -SAT_HI - CS_W'(1);
    localparam logic signed [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_AVG,
        S_CSUM,
        S_CMAG,
        S_CDIV,
        S_SAT,
        S_OUT
    } state_t;

    state_t                          state_reg;
    phase_t                          phase_reg;
    logic [SAMPLE_W-1:0]             win_mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0]           win_vld_reg;
    logic [SAMPLE_W-1:0]             rd_data_reg;
    logic [WIN_AW-1:0]               ptr_reg;
    logic [SUM_W-1:0]                sum_reg;
    logic [SAMPLE_W-1:0]             avg_reg;
    logic [SAMPLE_W-1:0]             smp_reg;
    logic signed [POSITION_BITS-1:0] pos_reg;
    logic signed [EDGE_W-1:0]        edge_reg;
    logic signed [EDGE_W-1:0]        rise_reg;
    logic signed [CS_W-1:0]          csum_reg;
    logic                            neg_reg;
    logic [MAG_W-1:0]                res_mag_reg;
    logic signed [POSITION_BITS-1:0] centre_reg;

    logic                            div_start_reg;
    logic [DIV_W-1:0]                div_dvd_reg;
    logic [DVS_W-1:0]                div_dvs_reg;
    logic                            div_done;
    logic [DVS_W-1:0]                div_rem;

    logic                            out_valid_reg;
    phase_t                          out_phase_reg;
    logic [SAMPLE_W-1:0]             out_avg_reg;
    logic                            out_found_reg;
    logic signed [POSITION_BITS-1:0] out_mid_reg;

    logic                            win_wr;
    logic [SAMPLE_W-1:0]             old_val;
    logic [SUM_W-1:0]                sum_next;
    logic [WIN_AW-1:0]               ptr_next;
    logic signed [EDGE_W-1:0]        edge_next;
    logic [REV_W-1:0]                rev_eff;
    logic                            wrap;
    logic signed [CS_W-1:0]          csum_next;
    logic [CS_W-1:0]                 csum_abs;
    logic signed [CS_W-1:0]          centre_full;
    logic [PROD_W-1:0]               avg_prod;
    logic [SAMPLE_W-1:0]             quo_avg;
    logic                            out_free;
    logic                            out_load;

    swma_div #(
        .DIV_W (DIV_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (div_dvd_reg),
        .divisor   (div_dvs_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign q_ready  = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign out_load = (state_reg == S_OUT) && out_free;

    assign old_val   = win_vld_reg[ptr_reg] ? rd_data_reg : '0;
    assign sum_next  = sum_reg - SUM_W'(old_val) + SUM_W'(smp_reg);
    assign ptr_next  = (ptr_reg == WIN_AW'(WINDOW_LEN - 1)) ? '0 : ptr_reg + WIN_AW'(1);
    assign edge_next = {pos_reg[POSITION_BITS-1], pos_reg}
                     - $signed({{(EDGE_W-LAG_W){1'b0}}, cfg.lag_steps});
    assign rev_eff   = (cfg.revolution_steps == '0) ? REV_W'(1) : cfg.revolution_steps;
    assign wrap      = (edge_reg < rise_reg);
    assign csum_next = {{(CS_W-EDGE_W){rise_reg[EDGE_W-1]}}, rise_reg}
                     + {{(CS_W-EDGE_W){edge_reg[EDGE_W-1]}}, edge_reg}
                     + (wrap ? $signed({{(CS_W-REV_W){1'b0}}, rev_eff}) : '0);
    assign csum_abs  = csum_reg[CS_W-1] ? CS_W'(-csum_reg) : CS_W'(csum_reg);
    assign centre_full = neg_reg ? -$signed({1'b0, res_mag_reg})
                                 : $signed({1'b0, res_mag_reg});
    assign avg_prod  = PROD_W'(sum_reg) * PROD_W'(AVG_RCP);
    assign quo_avg   = avg_prod[AVG_SH +: SAMPLE_W];
    assign win_wr    = (state_reg == S_READ);

    // Window store: registered read at the write pointer, one write per pushed sample.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= win_mem[ptr_reg];
        if (win_wr)
        begin
            win_mem[ptr_reg] <= smp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_SEEK_LOW;
            win_vld_reg   <= '0;
            ptr_reg       <= '0;
            sum_reg       <= '0;
            avg_reg       <= '0;
            smp_reg       <= '0;
            pos_reg       <= '0;
            edge_reg      <= '0;
            rise_reg      <= '0;
            csum_reg      <= '0;
            neg_reg       <= 1'b0;
            res_mag_reg   <= '0;
            centre_reg    <= '0;
            div_start_reg <= 1'b0;
            div_dvd_reg   <= '0;
            div_dvs_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_phase_reg <= PH_SEEK_LOW;
            out_avg_reg   <= '0;
            out_found_reg <= 1'b0;
            out_mid_reg   <= '0;
        end
        else
        begin
            div_start_reg <= (state_reg == S_CMAG) && wrap;
            if (out_valid_reg && out_ch.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        smp_reg <= q_sample;
                        pos_reg <= q_position;
                        if (q_kind == CMD_RESTART)
                        begin
                            phase_reg   <= PH_SEEK_LOW;
                            win_vld_reg <= '0;
                            ptr_reg     <= '0;
                            sum_reg     <= '0;
                            avg_reg     <= '0;
                            rise_reg    <= '0;
                            centre_reg  <= '0;
                            state_reg   <= S_OUT;
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_SEEK_LOW:
                                begin
                                    if (q_sample < cfg.low_threshold)
                                    begin
                                        phase_reg <= PH_SEEK_RISE;
                                    end
                                    state_reg <= S_OUT;
                                end
                                PH_SEEK_RISE:
                                begin
                                    // Zero sample while seeking the rise aborts the search.
                                    if (q_sample == '0)
                                    begin
                                        phase_reg <= PH_ABORTED;
                                        state_reg <= S_OUT;
                                    end
                                    else
                                    begin
                                        state_reg <= S_READ;
                                    end
                                end
                                PH_SEEK_FALL:
                                begin
                                    state_reg <= S_READ;
                                end
                                default:
                                begin
                                    // done and aborted hold until a restart
                                    state_reg <= S_OUT;
                                end
                            endcase
                        end
                    end
                end

                S_READ:
                begin
                    sum_reg              <= sum_next;
                    win_vld_reg[ptr_reg] <= 1'b1;
                    ptr_reg              <= ptr_next;
                    edge_reg             <= edge_next;
                    state_reg            <= S_AVG;
                end

                S_AVG:
                begin
                    avg_reg <= quo_avg;
                    if (phase_reg == PH_SEEK_RISE)
                    begin
                        if (quo_avg > cfg.high_threshold)
                        begin
                            rise_reg  <= edge_reg;
                            phase_reg <= PH_SEEK_FALL;
                        end
                        state_reg <= S_OUT;
                    end
                    else if (quo_avg < cfg.high_threshold)
                    begin
                        state_reg <= S_CSUM;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end

                S_CSUM:
                begin
                    csum_reg  <= csum_next;
                    state_reg <= S_CMAG;
                end

                S_CMAG:
                begin
                    // Halve toward zero on the magnitude; the sign comes back later.
                    neg_reg <= csum_reg[CS_W-1];
                    if (wrap)
                    begin
                        div_dvd_reg <= DIV_W'(csum_abs[CS_W-1:1]);
                        div_dvs_reg <= DVS_W'(rev_eff);
                        state_reg   <= S_CDIV;
                    end
                    else
                    begin
                        res_mag_reg <= csum_abs[CS_W-1:1];
                        state_reg   <= S_SAT;
                    end
                end

                S_CDIV:
                begin
                    if (div_done)
                    begin
                        res_mag_reg <= MAG_W'(div_rem);
                        state_reg   <= S_SAT;
                    end
                end

                S_SAT:
                begin
                    if (centre_full > SAT_HI)
                    begin
                        centre_reg <= POS_MAX;
                    end
                    else if (centre_full < SAT_LO)
                    begin
                        centre_reg <= POS_MIN;
                    end
                    else
                    begin
                        centre_reg <= centre_full[POSITION_BITS-1:0];
                    end
                    phase_reg <= PH_DONE;
                    state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_phase_reg <= phase_reg;
                        out_avg_reg   <= (phase_reg == PH_SEEK_LOW) ? '0 : avg_reg;
                        out_found_reg <= (phase_reg == PH_DONE);
                        out_mid_reg   <= (phase_reg == PH_DONE) ? centre_reg : '0;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.phase    = out_phase_reg;
    assign out_ch.average  = out_avg_reg;
    assign out_ch.found    = out_found_reg;
    assign out_ch.midpoint = out_mid_reg;

endmodule

// File: design/sensor_window_midpoint_align_unit.sv
// From input transfer to result valid: restart, seek_low, done and aborted items pass IDLE and
// OUT; a windowed sample adds READ and AVG (a reciprocal multiply forms the average); one that
// closes the high region adds CSUM, CMAG and SAT, and CDIV with the serial remainder when the
// midpoint wraps. Throughput: one item at a time; the back end takes the next item the cycle
// after the result register loads and holds while a result waits on a stall.
// Reset clears phase, window, sum and edges and loads the register defaults.
`include "sensor_window_midpoint_align_unit_assert.svh"

module sensor_window_midpoint_align_unit
    import swma_pkg::*;
#(
    parameter int WINDOW_LEN    = WINDOW_LEN_DEF,
    parameter int POSITION_BITS = POS_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    swma_in_if.sink               in_ch,
    swma_out_if.source            out_ch
);

    cfg_t                            cfg_reg;
    logic                            q_valid;
    logic                            q_ready;
    cmd_t                            q_kind;
    logic [SAMPLE_W-1:0]             q_sample;
    logic signed [POSITION_BITS-1:0] q_position;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_threshold    <= LOW_THRESHOLD_RST;
            cfg_reg.high_threshold   <= HIGH_THRESHOLD_RST;
            cfg_reg.revolution_steps <= REV_STEPS_RST;
            cfg_reg.lag_steps        <= LAG_STEPS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LOW_THRESHOLD:  cfg_reg.low_threshold    <= cfg_data[THRESH_W-1:0];
                REG_HIGH_THRESHOLD: cfg_reg.high_threshold   <= cfg_data[THRESH_W-1:0];
                REG_REV_STEPS:      cfg_reg.revolution_steps <= cfg_data[REV_W-1:0];
                REG_LAG_STEPS:      cfg_reg.lag_steps        <= cfg_data[LAG_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    swma_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_kind     (q_kind),
        .q_sample   (q_sample),
        .q_position (q_position)
    );

    swma_back #(
        .WINDOW_LEN    (WINDOW_LEN),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_kind     (q_kind),
        .q_sample   (q_sample),
        .q_position (q_position),
        .out_ch     (out_ch)
    );

    `SWMA_ASSERT_IMPLY(a_found_only_done, clk, rst_n, out_ch.valid,
        (out_ch.found == (out_ch.phase == PH_DONE)), "found flag disagrees with phase")
    `SWMA_ASSERT_IMPLY(a_seek_low_zero, clk, rst_n, out_ch.valid && (out_ch.phase == PH_SEEK_LOW),
        (out_ch.average == '0) && (out_ch.midpoint == '0), "seek_low result carries nonzero fields")
    `SWMA_ASSERT_NEXT(a_back_takes_one, clk, rst_n, q_valid && q_ready, !q_ready,
        "back end took a second item while busy")

endmodule

// File: test/sensor_window_midpoint_align_unit_tb.sv
// Self-checking bench for the sensor window midpoint align unit, scored against a local predictor.
module sensor_window_midpoint_align_unit_tb
    import swma_pkg::*;
();

    class alignment_tracker;
        typedef struct {
            phase_t                           search_phase;
            logic [SAMPLE_W-1:0]              average;
            logic                             found;
            logic signed [POS_BITS_DEF-1:0]   midpoint;
        } alignment_t;

        alignment_t expected_alignments[$];
        int errors;

        logic [THRESH_W-1:0] low_thr;
        logic [THRESH_W-1:0] high_thr;
        logic [REV_W-1:0]    rev_steps;
        logic [LAG_W-1:0]    lag;

        phase_t              search_phase;
        logic [SAMPLE_W-1:0] window_vals [WINDOW_LEN_DEF];
        int unsigned         window_sum;
        int                  slot;
        longint              rise_pos;
        longint              centre_pos;

        function new();
            errors    = 0;
            low_thr   = LOW_THRESHOLD_RST;
            high_thr  = HIGH_THRESHOLD_RST;
            rev_steps = REV_STEPS_RST;
            lag       = LAG_STEPS_RST;
            clear_search();
        endfunction

        function void clear_search();
            search_phase = PH_SEEK_LOW;
            foreach (window_vals[i])
                window_vals[i] = '0;
            window_sum = 0;
            slot       = 0;
            rise_pos   = 0;
            centre_pos = 0;
        endfunction

        function void set_register(cfg_reg_t idx, int unsigned value);
            case (idx)
                REG_LOW_THRESHOLD:  low_thr   = value[THRESH_W-1:0];
                REG_HIGH_THRESHOLD: high_thr  = value[THRESH_W-1:0];
                REG_REV_STEPS:      rev_steps = value[REV_W-1:0];
                REG_LAG_STEPS:      lag       = value[LAG_W-1:0];
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR @%0t: %s", $time, msg);
        endtask

        function int unsigned push_reading(logic [SAMPLE_W-1:0] reading);
            window_sum        = window_sum - window_vals[slot] + reading;
            window_vals[slot] = reading;
            slot              = (slot + 1) % WINDOW_LEN_DEF;
            return window_sum / WINDOW_LEN_DEF;
        endfunction

        // Wrap through one revolution when the fall lies before the rise.
        function longint centre_between(longint rise, longint fall);
            longint span = (rev_steps == 0) ? 64'sd1 : longint'(rev_steps);
            if (fall - rise < 0)
                return ((rise + fall + span) / 2) % span;
            return (rise + fall) / 2;
        endfunction

        function logic signed [POS_BITS_DEF-1:0] clamp_position(longint v);
            longint top = (longint'(1) <<< (POS_BITS_DEF - 1)) - 1;
            if (v > top)
                v = top;
            else if (v < -top - 1)
                v = -top - 1;
            return v[POS_BITS_DEF-1:0];
        endfunction

        function void predict_alignment(cmd_t op, logic [SAMPLE_W-1:0] reading,
                                        logic signed [POS_BITS_DEF-1:0] pos);
            alignment_t exp_item;
            longint     mark_pos = longint'(pos) - longint'(lag);
            if (op == CMD_RESTART)
                clear_search();
            else
            begin
                case (search_phase)
                    PH_SEEK_LOW:
                        if (reading < low_thr)
                            search_phase = PH_SEEK_RISE;
                    PH_SEEK_RISE:
                        if (reading == 0)
                            search_phase = PH_ABORTED;
                        else if (push_reading(reading) > high_thr)
                        begin
                            rise_pos     = mark_pos;
                            search_phase = PH_SEEK_FALL;
                        end
                    PH_SEEK_FALL:
                        if (push_reading(reading) < high_thr)
                        begin
                            centre_pos   = centre_between(rise_pos, mark_pos);
                            search_phase = PH_DONE;
                        end
                    default: ;
                endcase
            end
            exp_item.search_phase = search_phase;
            exp_item.average      = (search_phase == PH_SEEK_LOW) ? '0 :
                                    SAMPLE_W'(window_sum / WINDOW_LEN_DEF);
            exp_item.found        = (search_phase == PH_DONE);
            exp_item.midpoint     = (search_phase == PH_DONE) ? clamp_position(centre_pos) : '0;
            expected_alignments.push_back(exp_item);
        endfunction

        task check_alignment(logic [PHASE_W-1:0] ph, logic [SAMPLE_W-1:0] avg,
                             logic fnd, logic signed [POS_BITS_DEF-1:0] mid);
            alignment_t exp_item;
            if (expected_alignments.size() == 0)
            begin
                report($sformatf("unexpected result: phase %0d average %0d found %0d midpoint %0d",
                                 ph, avg, fnd, mid));
                return;
            end
            exp_item = expected_alignments.pop_front();
            if (ph !== exp_item.search_phase || avg !== exp_item.average ||
                fnd !== exp_item.found || mid !== exp_item.midpoint)
                report($sformatf({"got phase %0d average %0d found %0d midpoint %0d, ",
                                  "want phase %0d average %0d found %0d midpoint %0d"},
                                 ph, avg, fnd, mid, exp_item.search_phase, exp_item.average,
                                 exp_item.found, exp_item.midpoint));
        endtask
    endclass

    localparam int POS_W        = POS_BITS_DEF;
    localparam int ITEM_TARGET  = 700;
    localparam int ROUND_ITEMS  = 80;
    localparam int DRAIN_CYCLES = 60;
    localparam int IDLE_LIMIT   = 2000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    swma_in_if  sensor_ch ();
    swma_out_if align_ch ();

    alignment_tracker tracker;
    bit  calm = 1'b0;
    int  items_sent = 0;
    int  idle_cycles = 0;
    int  motor_pos;
    int  motor_span;
    bit  motor_circular;

    sensor_window_midpoint_align_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (sensor_ch),
        .out_ch    (align_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned pick_between(int unsigned lo, int unsigned hi);
        if (hi <= lo)
            return lo;
        return $urandom_range(hi, lo);
    endfunction

    // Mostly back to back, some short holes, a few long ones.
    function automatic int pick_gap();
        int roll = $urandom_range(99, 0);
        if (calm || roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_item(cmd_t op, logic [SAMPLE_W-1:0] reading, logic signed [POS_W-1:0] pos);
        int gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            sensor_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sensor_ch.valid    <= 1'b1;
        sensor_ch.op       <= op;
        sensor_ch.sample   <= reading;
        sensor_ch.position <= pos;
        @(posedge clk);
        while (!sensor_ch.ready)
            @(posedge clk);
        tracker.predict_alignment(op, reading, pos);
        items_sent++;
    endtask

    // Drop valid, wait for every result, then give the back end time to go quiet.
    task automatic settle();
        @(negedge clk);
        sensor_ch.valid <= 1'b0;
        while (tracker.expected_alignments.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_register(idx, value);
    endtask

    task automatic apply_settings(int round);
        int unsigned lo_v  = pick_between(50, 600);
        int unsigned hi_v  = pick_between(150, 900);
        int unsigned rev_v = pick_between(1, 4096);
        int unsigned lag_v = pick_between(0, 255);
        case ($urandom_range(11, 0))
            0: lo_v = 0;
            1: lo_v = 1023;
            default: ;
        endcase
        case ($urandom_range(11, 0))
            0: hi_v = 0;
            1: hi_v = 1023;
            default: ;
        endcase
        case ($urandom_range(9, 0))
            0: rev_v = 0;
            1: rev_v = 1;
            2: rev_v = 16384;
            3: rev_v = 32767;
            default: ;
        endcase
        case ($urandom_range(5, 0))
            0: lag_v = 0;
            1: lag_v = 255;
            default: ;
        endcase
        if (round == 0)
        begin
            lo_v  = 1023;
            hi_v  = 300;
            rev_v = 0;
            lag_v = 255;
        end
        else if (round == 1)
        begin
            lo_v  = 0;
            hi_v  = 1023;
            rev_v = 32767;
            lag_v = 0;
        end
        write_reg(REG_LOW_THRESHOLD, lo_v);
        write_reg(REG_HIGH_THRESHOLD, hi_v);
        write_reg(REG_REV_STEPS, rev_v);
        write_reg(REG_LAG_STEPS, lag_v);
    endtask

    task automatic step_motor(int unsigned reading);
        motor_pos += $urandom_range(4, 1);
        if (motor_circular && motor_pos >= motor_span)
            motor_pos -= motor_span;
        send_item(CMD_SAMPLE, SAMPLE_W'(reading), POS_W'(motor_pos));
    endtask

    // One pass over the sensor: restart, dip below low, climb into the high region, drop out.
    task automatic run_sweep();
        int unsigned lo_t   = tracker.low_thr;
        int unsigned hi_t   = tracker.high_thr;
        int unsigned rise_lo = (hi_t < 1023) ? hi_t + 1 : 1023;
        int unsigned fall_hi = (hi_t > 0) ? hi_t - 1 : 0;
        motor_span     = (tracker.rev_steps == 0) ? 1 : int'(tracker.rev_steps);
        motor_circular = $urandom_range(1, 0);
        if (!motor_circular)
            motor_pos = int'($urandom_range(65535, 0)) - 32768;
        else if (motor_span > 64)
            motor_pos = motor_span - 1 - int'($urandom_range(63, 0));
        else
            motor_pos = $urandom_range(motor_span - 1, 0);
        send_item(CMD_RESTART, SAMPLE_W'($urandom), POS_W'($urandom));
        repeat ($urandom_range(2, 0)) step_motor(pick_between(lo_t, 1023));
        step_motor((lo_t > 0) ? pick_between(0, lo_t - 1) : 0);
        repeat ($urandom_range(6, 0)) step_motor(pick_between(1, (hi_t > 0) ? hi_t : 1));
        if ($urandom_range(7, 0) == 0)
            step_motor(0);
        repeat ($urandom_range(18, 10)) step_motor(pick_between(rise_lo, 1023));
        repeat ($urandom_range(14, 8)) step_motor(pick_between(0, fall_hi));
        repeat ($urandom_range(2, 0)) step_motor(pick_between(0, 1023));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(3, 0))
            send_item(($urandom_range(5, 0) == 0) ? CMD_RESTART : CMD_SAMPLE,
                      SAMPLE_W'($urandom), POS_W'($urandom));
    endtask

    task automatic run_directed();
        send_item(CMD_SAMPLE, 10'd1023, 16'sd0);
        send_item(CMD_SAMPLE, 10'd275, 16'sd100);
        send_item(CMD_SAMPLE, 10'd274, 16'sd200);
        // Average sits exactly on the high threshold: no rise yet.
        for (int i = 0; i < 10; i++)
            send_item(CMD_SAMPLE, 10'd400, POS_W'(300 + i));
        send_item(CMD_SAMPLE, 10'd410, 16'sh7FFF);
        // Fall at the most negative position lands before the rise: wrapped centre.
        send_item(CMD_SAMPLE, 10'd310, 16'sh8000);
        send_item(CMD_SAMPLE, 10'd1023, 16'sd5);
        send_item(CMD_RESTART, 10'd1023, 16'shFFFF);
        send_item(CMD_SAMPLE, 10'd0, 16'sd7);
        send_item(CMD_SAMPLE, 10'd0, 16'sd8);
        send_item(CMD_SAMPLE, 10'd500, 16'sd9);
        send_item(CMD_RESTART, 10'd0, 16'sd0);
    endtask

    // Result side: random stalls, checked on every transfer.
    initial
    begin
        int stall_left;
        stall_left     = 0;
        align_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && !calm && $urandom_range(3, 0) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                align_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                align_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && align_ch.valid && align_ch.ready)
            tracker.check_alignment(align_ch.phase, align_ch.average, align_ch.found,
                                    align_ch.midpoint);

    always @(posedge clk)
    begin
        if (!rst_n || (sensor_ch.valid && sensor_ch.ready) || (align_ch.valid && align_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        tracker            = new();
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = REG_LOW_THRESHOLD;
        cfg_data           = '0;
        sensor_ch.valid    = 1'b0;
        sensor_ch.op       = CMD_SAMPLE;
        sensor_ch.sample   = '0;
        sensor_ch.position = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        for (int round = 0; items_sent < ITEM_TARGET; round++)
        begin
            int first_item;
            settle();
            apply_settings(round);
            calm       = (round % 4 == 3);
            first_item = items_sent;
            while (items_sent - first_item < ROUND_ITEMS)
            begin
                run_sweep();
                send_noise();
            end
        end
        calm = 1'b0;
        settle();

        if (tracker.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: files.f
+incdir+design
design/swma_pkg.sv
design/swma_if.sv
design/swma_front.sv
design/swma_div.sv
design/swma_back.sv
design/sensor_window_midpoint_align_unit.sv
test/sensor_window_midpoint_align_unit_tb.sv
